[src/dive_log_record_parser_unit_assert.svh]
// Assertion macros for the dive log record parser.
`ifndef DIVE_LOG_RECORD_PARSER_UNIT_ASSERT_SVH
`define DIVE_LOG_RECORD_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define DLRP_ASSERT_IMP(lbl, clk, rstn, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (con)) \
    else $error("dlrp assertion failed");
// Next-cycle implication.
`define DLRP_ASSERT_NXT(lbl, clk, rstn, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (con)) \
    else $error("dlrp assertion failed");
`else
`define DLRP_ASSERT_IMP(lbl, clk, rstn, ant, con)
`define DLRP_ASSERT_NXT(lbl, clk, rstn, ant, con)
`endif
`endif

[src/dlrp_pkg.sv]
// Shared types and constants of the dive log record parser.
package dlrp_pkg;

  // Result kinds
  typedef enum logic [3:0] {
    K_TIME     = 4'd0,
    K_DEPTH    = 4'd1,
    K_TEMP     = 4'd2,
    K_GAS_SW   = 4'd3,
    K_SETPOINT = 4'd4,
    K_PRESSURE = 4'd5,
    K_DECO     = 4'd6,
    K_NDL      = 4'd7,
    K_GAS_ENT  = 4'd8,
    K_TANK_ENT = 4'd9,
    K_DONE     = 4'd10
  } kind_e;

  // Done status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TRUNC     = 2'd1;
  localparam logic [1:0] STAT_GAS_FULL  = 2'd2;
  localparam logic [1:0] STAT_TANK_FULL = 2'd3;

  // Event type codes
  localparam logic [14:0] EV_DECO      = 15'd5;
  localparam logic [14:0] EV_GAS       = 15'd7;
  localparam logic [14:0] EV_SETPOINT  = 15'd8;
  localparam logic [14:0] EV_TANK      = 15'd15;
  localparam logic [14:0] EV_TANK_LIST = 15'd16;

  // Configuration register indexes
  typedef enum logic [2:0] {
    R_LONG_SAMPLES = 3'd0,
    R_SHORT_TANK   = 3'd1,
    R_INTERVAL     = 3'd2,
    R_SAMPLE_LIMIT = 3'd3,
    R_EVENT_LIMIT  = 3'd4
  } reg_idx_e;

  // One result item
  typedef struct packed {
    logic [3:0]         kind;
    logic [37:0]        time_s;
    logic [14:0]        depth_cm;
    logic signed [15:0] temperature_deci;
    logic [3:0]         entry_index;
    logic [7:0]         oxygen_pct;
    logic [7:0]         helium_pct;
    logic [15:0]        tank_id;
    logic [15:0]        reading;
    logic [15:0]        begin_pressure;
    logic [1:0]         status;
    logic               last_of_run;
  } res_t;

  // Sample interval in seconds; codes above five saturate
  function automatic logic [5:0] interval_s(input logic [2:0] sel);
    logic [5:0] v;
    case (sel)
      3'd0:    v = 6'd1;
      3'd1:    v = 6'd2;
      3'd2:    v = 6'd5;
      3'd3:    v = 6'd10;
      3'd4:    v = 6'd30;
      default: v = 6'd60;
    endcase
    return v;
  endfunction

endpackage

[src/dlrp_rec_if.sv]
// Record byte channel.
interface dlrp_rec_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

[src/dlrp_res_if.sv]
// Result item channel.
interface dlrp_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [37:0]        time_s;
  logic [14:0]        depth_cm;
  logic signed [15:0] temperature_deci;
  logic [3:0]         entry_index;
  logic [7:0]         oxygen_pct;
  logic [7:0]         helium_pct;
  logic [15:0]        tank_id;
  logic [15:0]        reading;
  logic [15:0]        begin_pressure;
  logic [1:0]         status;
  logic               last_of_run;
  modport source (output valid, kind, time_s, depth_cm, temperature_deci, entry_index,
                  oxygen_pct, helium_pct, tank_id, reading, begin_pressure, status,
                  last_of_run, input ready);
  modport sink (input valid, kind, time_s, depth_cm, temperature_deci, entry_index,
                oxygen_pct, helium_pct, tank_id, reading, begin_pressure, status,
                last_of_run, output ready);
endinterface

[src/dive_log_record_parser_unit.sv]
// Top level of the dive log record parser.
// Takes one record body byte per item and returns its result items in order; the last
// result of a byte carries last_of_run. A small sequencer handles each byte in turn and
// is not ready until all of its results have left the one-item holding stage. A plain
// byte passes the take, last-byte and flush states; a completed event adds the event state,
// and a gas or tank search adds one compare per table entry; a finished sample walks up to
// 7 + TANK_SLOTS emission steps; the end of the record walks up to GAS_SLOTS + TANK_SLOTS + 3
// steps. A stalled result port holds the sequencer until its results are taken.
// Configuration is by APB, register i at byte address 4*i.
module dive_log_record_parser_unit #(
  parameter int GAS_SLOTS  = 11,
  parameter int TANK_SLOTS = 11
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dlrp_rec_if.sink     rec_i,
  dlrp_res_if.source   res_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  `include "dive_log_record_parser_unit_assert.svh"

  localparam int GIW    = (GAS_SLOTS > 1) ? $clog2(GAS_SLOTS) : 1;
  localparam int GCW    = $clog2(GAS_SLOTS + 1);
  localparam int TIW    = (TANK_SLOTS > 1) ? $clog2(TANK_SLOTS) : 1;
  localparam int TCW    = $clog2(TANK_SLOTS + 1);
  localparam int MAXLEN = (4 + 2 * TANK_SLOTS > 16) ? 4 + 2 * TANK_SLOTS : 16;
  localparam int BCW    = $clog2(MAXLEN + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TAKE, S_EVT, S_GSRCH, S_TSRCH, S_FAIL, S_SMP, S_LAST, S_REC, S_FLUSH
  } state_e;
  typedef enum logic [1:0] {PH_WLO, PH_WHI, PH_EVENT, PH_SAMPLE} phase_e;
  typedef enum logic [1:0] {SS_RUN, SS_LIMIT, SS_ERROR, SS_DONE} stop_e;

  // Pending flag bits
  localparam int PF_GAS  = 0;
  localparam int PF_SP   = 1;
  localparam int PF_DECO = 2;

  state_e st_q, st_d;
  phase_e ph_q, ph_d;
  stop_e  stop_q, stop_d;

  logic [7:0]            byte_q, byte_d;
  logic                  last_q, last_d;
  logic [BCW-1:0]        bc_q, bc_d;
  logic [15:0]           word_q, word_d;
  logic [14:0]           etype_q, etype_d;
  logic [31:0]           pay_q, pay_d;
  logic [31:0]           smp_q, smp_d;
  logic [31:0]           evt_q, evt_d;
  logic [37:0]           time_q, time_d;
  logic [GCW-1:0]        gcnt_q, gcnt_d;
  logic [15:0]           pgas_q, pgas_d;
  logic                  pgas_v_q, pgas_v_d;
  logic [GIW-1:0]        cgas_q, cgas_d;
  logic [TCW-1:0]        tcnt_q, tcnt_d;
  logic [15:0]           ptank_q, ptank_d;
  logic                  ptank_v_q, ptank_v_d;
  logic [TIW-1:0]        ctank_q, ctank_d;
  logic [TANK_SLOTS-1:0] ppress_q, ppress_d;
  logic [2:0]            pflag_q, pflag_d;
  logic [7:0]            sp_q, sp_d;
  logic [15:0]           deco_q, deco_d;
  logic [2:0]            sub_q, sub_d;
  logic [GCW-1:0]        gidx_q, gidx_d;
  logic [TCW-1:0]        tidx_q, tidx_d;
  logic [1:0]            fail_q, fail_d;

  // Configuration registers
  logic        long_q, short_q;
  logic [2:0]  ival_q;
  logic [31:0] slim_q, elim_q;

  // Output holding stage and output register
  dlrp_pkg::res_t hold_q, hold_d, out_q, out_d, gen;
  logic           hold_v_q, hold_v_d, out_v_q, out_v_d;
  logic           gen_v, out_free, can_place, adv;

  // Tables
  logic [15:0] gas_tab_q [GAS_SLOTS];
  logic [47:0] tank_tab_q [TANK_SLOTS];
  logic [GIW-1:0] gra, gwa;
  logic [TIW-1:0] tra, twa;
  logic [15:0]    grd, gwd;
  logic [47:0]    trd, twd;
  logic           gwe, twe;

  logic [BCW-1:0] bc_inc, ev_end, smp_end;
  logic [15:0]    wfull;
  logic           trunc;

  // APB
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:2])
      dlrp_pkg::R_LONG_SAMPLES: prdata = {31'd0, long_q};
      dlrp_pkg::R_SHORT_TANK:   prdata = {31'd0, short_q};
      dlrp_pkg::R_INTERVAL:     prdata = {29'd0, ival_q};
      dlrp_pkg::R_SAMPLE_LIMIT: prdata = slim_q;
      dlrp_pkg::R_EVENT_LIMIT:  prdata = elim_q;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q  <= 1'b0;
      short_q <= 1'b0;
      ival_q  <= '0;
      slim_q  <= '0;
      elim_q  <= '0;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        dlrp_pkg::R_LONG_SAMPLES: long_q  <= pwdata[0];
        dlrp_pkg::R_SHORT_TANK:   short_q <= pwdata[0];
        dlrp_pkg::R_INTERVAL:     ival_q  <= pwdata[2:0];
        dlrp_pkg::R_SAMPLE_LIMIT: slim_q  <= pwdata;
        dlrp_pkg::R_EVENT_LIMIT:  elim_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // Table read ports, one address each
  assign gra = (st_q == S_SMP) ? cgas_q : gidx_q[GIW-1:0];
  assign tra = (st_q == S_TSRCH || st_q == S_SMP || st_q == S_REC) ? tidx_q[TIW-1:0]
                                                                  : ctank_q;
  assign grd = gas_tab_q[gra];
  assign trd = tank_tab_q[tra];

  always_ff @(posedge clk_i) begin
    if (gwe) gas_tab_q[gwa] <= gwd;
    if (twe) tank_tab_q[twa] <= twd;
  end

  // Byte decode helpers
  assign bc_inc  = bc_q + BCW'(1);
  assign smp_end = long_q ? BCW'(16) : BCW'(2);
  assign wfull   = {byte_q, word_q[7:0]};
  always_comb begin
    case (etype_q)
      dlrp_pkg::EV_DECO, dlrp_pkg::EV_GAS: ev_end = BCW'(6);
      dlrp_pkg::EV_SETPOINT:               ev_end = BCW'(5);
      dlrp_pkg::EV_TANK:                   ev_end = short_q ? BCW'(8) : BCW'(10);
      dlrp_pkg::EV_TANK_LIST:              ev_end = BCW'(4 + 2 * TANK_SLOTS);
      default:                             ev_end = BCW'(4);
    endcase
  end
  assign trunc = (stop_q == SS_RUN) && (ph_q == PH_EVENT || ph_q == PH_SAMPLE);

  assign out_free  = !out_v_q || res_o.ready;
  assign can_place = !hold_v_q || out_free;
  assign adv       = !gen_v || can_place;

  // Sequencer
  always_comb begin
    st_d = st_q;  ph_d = ph_q;  stop_d = stop_q;
    byte_d = byte_q;  last_d = last_q;  bc_d = bc_q;  word_d = word_q;
    etype_d = etype_q;  pay_d = pay_q;  smp_d = smp_q;  evt_d = evt_q;
    time_d = time_q;  gcnt_d = gcnt_q;  pgas_d = pgas_q;  pgas_v_d = pgas_v_q;
    cgas_d = cgas_q;  tcnt_d = tcnt_q;  ptank_d = ptank_q;  ptank_v_d = ptank_v_q;
    ctank_d = ctank_q;  ppress_d = ppress_q;  pflag_d = pflag_q;  sp_d = sp_q;
    deco_d = deco_q;  sub_d = sub_q;  gidx_d = gidx_q;  tidx_d = tidx_q;
    fail_d = fail_q;
    hold_d = hold_q;  hold_v_d = hold_v_q;  out_d = out_q;  out_v_d = out_v_q;
    gwe = 1'b0;  gwa = gcnt_q[GIW-1:0];  gwd = pay_q[15:0];
    twe = 1'b0;  twa = tra;  twd = {pay_q[31:16], trd[31:0]};
    gen_v = 1'b0;
    gen = '0;
    gen.time_s = time_q;

    if (out_v_q && res_o.ready) out_v_d = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (rec_i.valid) begin
          byte_d = rec_i.data_byte;
          last_d = rec_i.last_byte;
          st_d   = S_TAKE;
          if (rec_i.first_byte) begin
            ph_d = PH_WLO;  stop_d = SS_RUN;  bc_d = '0;  word_d = '0;  etype_d = '0;
            pay_d = '0;  smp_d = '0;  evt_d = '0;  time_d = '0;  gcnt_d = '0;
            pgas_d = '0;  pgas_v_d = 1'b0;  cgas_d = '0;  tcnt_d = '0;  ptank_d = '0;
            ptank_v_d = 1'b0;  ctank_d = '0;  ppress_d = '0;  pflag_d = '0;
            sp_d = '0;  deco_d = '0;
          end
        end
      end

      S_TAKE: begin
        st_d = S_LAST;
        if (stop_q == SS_RUN) begin
          unique case (ph_q)
            PH_WLO: begin
              word_d = {8'd0, byte_q};
              ph_d   = PH_WHI;
            end
            PH_WHI: begin
              word_d = wfull;
              bc_d   = '0;
              pay_d  = '0;
              if (wfull[15]) begin
                if (evt_q >= elim_q) stop_d = SS_LIMIT;
                else begin
                  etype_d = wfull[14:0];
                  ph_d    = PH_EVENT;
                end
              end else begin
                if (smp_q >= slim_q) stop_d = SS_LIMIT;
                else ph_d = PH_SAMPLE;
              end
            end
            PH_EVENT: begin
              if (bc_q >= BCW'(4) && bc_q < BCW'(8)) pay_d[8*bc_q[1:0] +: 8] = byte_q;
              bc_d = bc_inc;
              if (bc_inc >= ev_end) begin
                ph_d = PH_WLO;
                st_d = S_EVT;
              end
            end
            PH_SAMPLE: begin
              if (bc_q < BCW'(2)) pay_d[8*bc_q[0] +: 8] = byte_q;
              bc_d = bc_inc;
              if (bc_inc >= smp_end) begin
                ph_d   = PH_WLO;
                time_d = time_q + 38'(dlrp_pkg::interval_s(ival_q));
                sub_d  = '0;
                tidx_d = '0;
                st_d   = S_SMP;
              end
            end
            default: ;
          endcase
        end
      end

      // Completed event
      S_EVT: begin
        st_d = S_LAST;
        case (etype_q)
          dlrp_pkg::EV_DECO: begin
            deco_d = pay_q[15:0];
            pflag_d[PF_DECO] = 1'b1;
            evt_d = evt_q + 32'd1;
          end
          dlrp_pkg::EV_SETPOINT: begin
            sp_d = pay_q[7:0];
            pflag_d[PF_SP] = 1'b1;
            evt_d = evt_q + 32'd1;
          end
          dlrp_pkg::EV_GAS: begin
            if (pgas_v_q && pgas_q == pay_q[15:0]) evt_d = evt_q + 32'd1;
            else begin
              gidx_d = '0;
              st_d   = S_GSRCH;
            end
          end
          dlrp_pkg::EV_TANK: begin
            if (ptank_v_q && ptank_q == pay_q[15:0]) begin
              twe = 1'b1;
              ppress_d[ctank_q] = 1'b1;
              evt_d = evt_q + 32'd1;
            end else begin
              tidx_d = '0;
              st_d   = S_TSRCH;
            end
          end
          default: evt_d = evt_q + 32'd1;
        endcase
      end

      // Gas table lookup, one entry a cycle
      S_GSRCH: begin
        if (gidx_q < gcnt_q) begin
          if (grd == pay_q[15:0]) begin
            cgas_d = gidx_q[GIW-1:0];
            pgas_d = pay_q[15:0];  pgas_v_d = 1'b1;
            pflag_d[PF_GAS] = 1'b1;
            evt_d = evt_q + 32'd1;
            st_d  = S_LAST;
          end else gidx_d = gidx_q + GCW'(1);
        end else if (gcnt_q >= GCW'(GAS_SLOTS)) begin
          fail_d = dlrp_pkg::STAT_GAS_FULL;
          st_d   = S_FAIL;
        end else begin
          gwe    = 1'b1;
          cgas_d = gcnt_q[GIW-1:0];
          gcnt_d = gcnt_q + GCW'(1);
          pgas_d = pay_q[15:0];  pgas_v_d = 1'b1;
          pflag_d[PF_GAS] = 1'b1;
          evt_d = evt_q + 32'd1;
          st_d  = S_LAST;
        end
      end

      // Tank table lookup, one entry a cycle
      S_TSRCH: begin
        if (tidx_q < tcnt_q) begin
          if (trd[15:0] == pay_q[15:0]) begin
            twe = 1'b1;
            ctank_d = tidx_q[TIW-1:0];
            ppress_d[tidx_q[TIW-1:0]] = 1'b1;
            ptank_d = pay_q[15:0];  ptank_v_d = 1'b1;
            evt_d = evt_q + 32'd1;
            st_d  = S_LAST;
          end else tidx_d = tidx_q + TCW'(1);
        end else if (tcnt_q >= TCW'(TANK_SLOTS)) begin
          fail_d = dlrp_pkg::STAT_TANK_FULL;
          st_d   = S_FAIL;
        end else begin
          twe = 1'b1;
          twa = tcnt_q[TIW-1:0];
          twd = {pay_q[31:16], pay_q[31:16], pay_q[15:0]};
          ctank_d = tcnt_q[TIW-1:0];
          ppress_d[tcnt_q[TIW-1:0]] = 1'b1;
          tcnt_d  = tcnt_q + TCW'(1);
          ptank_d = pay_q[15:0];  ptank_v_d = 1'b1;
          evt_d = evt_q + 32'd1;
          st_d  = S_LAST;
        end
      end

      // Table full: report and stop
      S_FAIL: begin
        gen_v = 1'b1;
        gen.kind = dlrp_pkg::K_DONE;
        gen.status = fail_q;
        if (adv) begin
          stop_d = SS_ERROR;
          st_d   = S_FLUSH;
        end
      end

      // Sample results, one step a cycle unless the result path stalls
      S_SMP: begin
        gen.depth_cm = word_q[14:0];
        gen.temperature_deci = signed'(pay_q[15:0]);
        case (sub_q)
          3'd0: begin gen_v = 1'b1; gen.kind = dlrp_pkg::K_TIME; end
          3'd1: begin gen_v = 1'b1; gen.kind = dlrp_pkg::K_DEPTH; end
          3'd2: begin gen_v = 1'b1; gen.kind = dlrp_pkg::K_TEMP; end
          3'd3: begin
            gen_v = pflag_q[PF_GAS];
            gen.kind = dlrp_pkg::K_GAS_SW;
            gen.entry_index = 4'(cgas_q);
            gen.oxygen_pct = grd[7:0];
            gen.helium_pct = grd[15:8];
          end
          3'd4: begin
            gen_v = pflag_q[PF_SP];
            gen.kind = dlrp_pkg::K_SETPOINT;
            gen.reading = {8'd0, sp_q};
          end
          3'd5: begin
            gen_v = (tidx_q < tcnt_q) && ppress_q[tidx_q[TIW-1:0]];
            gen.kind = dlrp_pkg::K_PRESSURE;
            gen.entry_index = 4'(tidx_q[TIW-1:0]);
            gen.tank_id = trd[15:0];
            gen.reading = trd[47:32];
            gen.begin_pressure = trd[31:16];
          end
          default: begin
            gen_v = pflag_q[PF_DECO];
            gen.kind = (deco_q != 16'd0) ? dlrp_pkg::K_DECO : dlrp_pkg::K_NDL;
            gen.reading = deco_q;
          end
        endcase
        if (adv) begin
          if (sub_q == 3'd5) begin
            if (tidx_q < tcnt_q) tidx_d = tidx_q + TCW'(1);
            else sub_d = 3'd6;
          end else if (sub_q == 3'd6) begin
            pflag_d  = '0;
            ppress_d = '0;
            smp_d    = smp_q + 32'd1;
            st_d     = S_LAST;
          end else sub_d = sub_q + 3'd1;
        end
      end

      S_LAST: begin
        if (last_q && (stop_q == SS_RUN || stop_q == SS_LIMIT)) begin
          sub_d  = trunc ? 3'd0 : 3'd1;
          gidx_d = '0;
          tidx_d = '0;
          st_d   = S_REC;
        end else st_d = S_FLUSH;
      end

      // End of record: table entries then done, or a truncated done alone
      S_REC: begin
        case (sub_q)
          3'd0: begin
            gen_v = 1'b1;
            gen.kind = dlrp_pkg::K_DONE;
            gen.status = dlrp_pkg::STAT_TRUNC;
            if (adv) begin
              stop_d = SS_DONE;
              st_d   = S_FLUSH;
            end
          end
          3'd1: begin
            gen_v = gidx_q < gcnt_q;
            gen.kind = dlrp_pkg::K_GAS_ENT;
            gen.entry_index = 4'(gidx_q[GIW-1:0]);
            gen.oxygen_pct = grd[7:0];
            gen.helium_pct = grd[15:8];
            if (adv) begin
              if (gen_v) gidx_d = gidx_q + GCW'(1);
              else sub_d = 3'd2;
            end
          end
          3'd2: begin
            gen_v = tidx_q < tcnt_q;
            gen.kind = dlrp_pkg::K_TANK_ENT;
            gen.entry_index = 4'(tidx_q[TIW-1:0]);
            gen.tank_id = trd[15:0];
            gen.reading = trd[47:32];
            gen.begin_pressure = trd[31:16];
            if (adv) begin
              if (gen_v) tidx_d = tidx_q + TCW'(1);
              else sub_d = 3'd3;
            end
          end
          default: begin
            gen_v = 1'b1;
            gen.kind = dlrp_pkg::K_DONE;
            gen.status = dlrp_pkg::STAT_OK;
            if (adv) begin
              stop_d = SS_DONE;
              st_d   = S_FLUSH;
            end
          end
        endcase
      end

      // Release the held item as the last of this byte
      S_FLUSH: begin
        if (!hold_v_q) st_d = S_IDLE;
        else if (out_free) begin
          out_d = hold_q;
          out_d.last_of_run = 1'b1;
          out_v_d  = 1'b1;
          hold_v_d = 1'b0;
          st_d     = S_IDLE;
        end
      end

      default: st_d = S_IDLE;
    endcase

    // New item enters the holding stage, pushing the previous one out
    if (gen_v && can_place) begin
      if (hold_v_q) begin
        out_d = hold_q;
        out_d.last_of_run = 1'b0;
        out_v_d = 1'b1;
      end
      hold_d   = gen;
      hold_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;  ph_q <= PH_WLO;  stop_q <= SS_RUN;
      byte_q <= '0;  last_q <= 1'b0;  bc_q <= '0;  word_q <= '0;  etype_q <= '0;
      pay_q <= '0;  smp_q <= '0;  evt_q <= '0;  time_q <= '0;  gcnt_q <= '0;
      pgas_q <= '0;  pgas_v_q <= 1'b0;  cgas_q <= '0;  tcnt_q <= '0;  ptank_q <= '0;
      ptank_v_q <= 1'b0;  ctank_q <= '0;  ppress_q <= '0;  pflag_q <= '0;
      sp_q <= '0;  deco_q <= '0;  sub_q <= '0;  gidx_q <= '0;  tidx_q <= '0;
      fail_q <= '0;  hold_v_q <= 1'b0;  out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;  ph_q <= ph_d;  stop_q <= stop_d;
      byte_q <= byte_d;  last_q <= last_d;  bc_q <= bc_d;  word_q <= word_d;
      etype_q <= etype_d;  pay_q <= pay_d;  smp_q <= smp_d;  evt_q <= evt_d;
      time_q <= time_d;  gcnt_q <= gcnt_d;  pgas_q <= pgas_d;  pgas_v_q <= pgas_v_d;
      cgas_q <= cgas_d;  tcnt_q <= tcnt_d;  ptank_q <= ptank_d;
      ptank_v_q <= ptank_v_d;  ctank_q <= ctank_d;  ppress_q <= ppress_d;
      pflag_q <= pflag_d;  sp_q <= sp_d;  deco_q <= deco_d;  sub_q <= sub_d;
      gidx_q <= gidx_d;  tidx_q <= tidx_d;  fail_q <= fail_d;
      hold_v_q <= hold_v_d;  out_v_q <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  // Ports
  assign rec_i.ready           = (st_q == S_IDLE);
  assign res_o.valid           = out_v_q;
  assign res_o.kind            = out_q.kind;
  assign res_o.time_s          = out_q.time_s;
  assign res_o.depth_cm        = out_q.depth_cm;
  assign res_o.temperature_deci = out_q.temperature_deci;
  assign res_o.entry_index     = out_q.entry_index;
  assign res_o.oxygen_pct      = out_q.oxygen_pct;
  assign res_o.helium_pct      = out_q.helium_pct;
  assign res_o.tank_id         = out_q.tank_id;
  assign res_o.reading         = out_q.reading;
  assign res_o.begin_pressure  = out_q.begin_pressure;
  assign res_o.status          = out_q.status;
  assign res_o.last_of_run     = out_q.last_of_run;

  // Checks
  `DLRP_ASSERT_IMP(a_idle_hold_empty, clk_i, rst_ni, st_q == S_IDLE, !hold_v_q)
  `DLRP_ASSERT_IMP(a_gas_count_range, clk_i, rst_ni, 1'b1, gcnt_q <= GCW'(GAS_SLOTS))
  `DLRP_ASSERT_IMP(a_tank_count_range, clk_i, rst_ni, 1'b1, tcnt_q <= TCW'(TANK_SLOTS))
  `DLRP_ASSERT_NXT(a_flush_to_idle, clk_i, rst_ni,
                   st_q == S_FLUSH && !hold_v_q, st_q == S_IDLE)

endmodule
